// ----- design/jse_pkg.sv -----
// shared types and byte constants for the json string escaper
`timescale 1ns / 1ps
`default_nettype none
package jse_pkg;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	localparam logic [7:0] C_QUOTE  = 8'h22;
	localparam logic [7:0] C_BSLASH = 8'h5C;
	localparam logic [7:0] C_REPL0  = 8'hEF;
	localparam logic [7:0] C_REPL1  = 8'hBF;
	localparam logic [7:0] C_REPL2  = 8'hBD;
	localparam logic [7:0] C_LEAD2  = 8'hC2;
	localparam logic [7:0] C_LEAD3  = 8'hE0;
	localparam logic [7:0] C_LEAD4  = 8'hF0;
	localparam logic [7:0] C_BADLD  = 8'hF5;
	localparam logic [7:0] C_SURR   = 8'hED;
	localparam logic [7:0] C_MAXLD  = 8'hF4;
	localparam logic [7:0] C_LIM3   = 8'hA0;
	localparam logic [7:0] C_LIM4   = 8'h90;
	localparam logic [1:0] C_CONT   = 2'b10;

	// one item's output plan: open quote, passed bytes, replacements,
	// one escaped ascii byte, close quote, in that order
	typedef struct packed {
		logic            open;
		logic [2:0]      pass_n;
		logic [3:0][7:0] pass;
		logic [2:0]      repl_n;
		logic            asc_en;
		logic [6:0]      asc;
		logic            close;
	} desc_t;

endpackage
`default_nettype wire

// ----- design/jse_front.sv -----
// front end: utf-8 state tracking and per-item output planning
`timescale 1ns / 1ps
`default_nettype none
module jse_front (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              valid,
	output logic             ready,
	input  wire  [7:0]       data_byte,
	input  wire              first,
	input  wire              last,
	input  wire              no_byte,
	input  wire              q_full,
	output logic             push,
	output jse_pkg::desc_t   desc
);
	import jse_pkg::*;

	logic [2:0][7:0] hb_q;
	logic [2:0][7:0] hb_n;
	logic [1:0]      hc_q;
	logic [1:0]      hc_n;
	logic [2:0]      el_q;
	logic [2:0]      el_n;
	logic            ins_q;
	logic            open;
	logic [1:0]      k;
	logic [2:0]      el;
	logic            ok;
	logic            fresh;
	logic            acc;
	logic            nonempty;

	assign ready = !q_full;
	assign acc   = valid && ready;

	always_comb begin
		open  = first || !ins_q;
		k     = open ? 2'd0 : hc_q;
		el    = open ? 3'd0 : el_q;
		desc  = '0;
		desc.open  = open;
		desc.close = last;
		hb_n  = hb_q;
		hc_n  = k;
		el_n  = el;
		ok    = 1'b0;
		fresh = 1'b0;
		if (!no_byte) begin
			if (el != 3'd0 && k != 2'd0) begin
				ok = data_byte[7:6] == C_CONT;
				if (k == 2'd1) begin
					// tighter second-byte ranges for overlong, surrogate, too-large
					if (hb_q[0] == C_LEAD3 && data_byte < C_LIM3) ok = 1'b0;
					if (hb_q[0] == C_SURR && data_byte >= C_LIM3) ok = 1'b0;
					if (hb_q[0] == C_LEAD4 && data_byte < C_LIM4) ok = 1'b0;
					if (hb_q[0] == C_MAXLD && data_byte >= C_LIM4) ok = 1'b0;
				end
				if (ok) begin
					if ({1'b0, k} + 3'd1 >= el || k == 2'd3) begin
						desc.pass_n = {1'b0, k} + 3'd1;
						for (int j = 0; j < 3; j++) begin
							desc.pass[j] = hb_q[j];
						end
						desc.pass[k] = data_byte;
						hc_n = 2'd0;
						el_n = 3'd0;
					end else begin
						hb_n[k] = data_byte;
						hc_n    = k + 2'd1;
					end
				end else begin
					desc.repl_n = {1'b0, k};
					fresh       = 1'b1;
				end
			end else begin
				fresh = 1'b1;
			end
			if (fresh) begin
				hc_n = 2'd0;
				el_n = 3'd0;
				if (!data_byte[7]) begin
					desc.asc_en = 1'b1;
					desc.asc    = data_byte[6:0];
				end else if (data_byte < C_LEAD2 || data_byte >= C_BADLD) begin
					desc.repl_n = desc.repl_n + 3'd1;
				end else begin
					hb_n[0] = data_byte;
					hc_n    = 2'd1;
					el_n    = (data_byte < C_LEAD3) ? 3'd2 :
					          ((data_byte < C_LEAD4) ? 3'd3 : 3'd4);
				end
			end
		end
		// truncated sequence at end of string
		if (last) begin
			desc.repl_n = desc.repl_n + {1'b0, hc_n};
			hc_n = 2'd0;
			el_n = 3'd0;
		end
	end

	assign nonempty = desc.open || desc.close || desc.asc_en ||
	                  (desc.pass_n != 3'd0) || (desc.repl_n != 3'd0);
	assign push = acc && nonempty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hc_q  <= 2'd0;
			el_q  <= 3'd0;
			ins_q <= 1'b0;
		end else if (acc) begin
			hc_q  <= hc_n;
			el_q  <= el_n;
			ins_q <= !last;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			hb_q <= hb_n;
		end
	end

endmodule
`default_nettype wire

// ----- design/jse_queue.sv -----
// short queue of output plans between front and back
`timescale 1ns / 1ps
`default_nettype none
module jse_queue (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  jse_pkg::desc_t   din,
	input  wire              pop,
	output jse_pkg::desc_t   dout,
	output logic             full,
	output logic             empty
);
	import jse_pkg::*;

	desc_t          mem [QDEPTH];
	logic [QAW-1:0] wr_q;
	logic [QAW-1:0] rd_q;
	logic [QAW:0]   cnt_q;
	logic           do_push;
	logic           do_pop;

	assign full    = cnt_q == (QAW+1)'(QDEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 1'b1;
			if (do_pop) rd_q <= rd_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

// ----- design/jse_back.sv -----
// back end: expands plans into output bytes, one word per cycle unless m_tready stalls it
`timescale 1ns / 1ps
`default_nettype none
module jse_back (
	input  wire              clk,
	input  wire              arst_n,
	input  jse_pkg::desc_t   head,
	input  wire              q_empty,
	output logic             pop,
	output logic             m_tvalid,
	input  wire              m_tready,
	output logic [7:0]       m_tdata,
	output logic             m_tlast,
	output logic             m_tuser
);
	import jse_pkg::*;

	typedef enum logic [4:0] {
		PH_OPEN  = 5'b00001,
		PH_PASS  = 5'b00010,
		PH_REPL  = 5'b00100,
		PH_ASC   = 5'b01000,
		PH_CLOSE = 5'b10000
	} ph_t;

	desc_t      cur_q;
	ph_t        phase_q;
	logic       active_q;
	logic [2:0] idx_q;
	logic [2:0] rep_q;
	logic [1:0] sub_q;

	logic       go;
	logic       fire;
	logic [4:0] ne_cur;
	logic [4:0] ne_head;
	logic [4:0] rest;
	logic [4:0] nxt;
	logic [4:0] head_ph;
	logic [4:0] ph_bits;
	logic [7:0] obyte;
	logic       pend;
	logic       send;
	logic       run_end;
	logic [7:0] named;
	logic [2:0] elen;
	logic [7:0] ebyte;
	logic [7:0] ab;

	function automatic logic [7:0] hex_digit(input logic [3:0] n);
		return (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h57 + {4'd0, n});
	endfunction

	assign ne_cur  = {cur_q.close, cur_q.asc_en, cur_q.repl_n != 3'd0,
	                  cur_q.pass_n != 3'd0, cur_q.open};
	assign ne_head = {head.close, head.asc_en, head.repl_n != 3'd0,
	                  head.pass_n != 3'd0, head.open};
	assign head_ph = ne_head & (~ne_head + 5'd1);
	assign ph_bits = phase_q;
	// nonempty phases strictly after the current one, lowest first
	assign rest    = ne_cur & ~({ph_bits[3:0], 1'b0} - 5'd1);
	assign nxt     = rest & (~rest + 5'd1);

	// escape of the ascii byte
	always_comb begin
		ab = {1'b0, cur_q.asc};
		case (ab)
			8'h22:   named = 8'h22;
			8'h5C:   named = 8'h5C;
			8'h08:   named = 8'h62;
			8'h0C:   named = 8'h66;
			8'h0A:   named = 8'h6E;
			8'h0D:   named = 8'h72;
			8'h09:   named = 8'h74;
			default: named = 8'h00;
		endcase
		if (named != 8'h00) elen = 3'd2;
		else if (ab < 8'h20) elen = 3'd6;
		else elen = 3'd1;
		case (idx_q)
			3'd0:    ebyte = (elen == 3'd1) ? ab : C_BSLASH;
			3'd1:    ebyte = (elen == 3'd2) ? named : 8'h75;
			3'd2:    ebyte = 8'h30;
			3'd3:    ebyte = 8'h30;
			3'd4:    ebyte = hex_digit({3'd0, ab[4]});
			default: ebyte = hex_digit(ab[3:0]);
		endcase
	end

	always_comb begin
		obyte = C_QUOTE;
		pend  = 1'b1;
		send  = 1'b0;
		case (phase_q)
			PH_OPEN: begin
				obyte = C_QUOTE;
			end
			PH_PASS: begin
				obyte = cur_q.pass[idx_q[1:0]];
				pend  = idx_q == cur_q.pass_n - 3'd1;
			end
			PH_REPL: begin
				obyte = (sub_q == 2'd0) ? C_REPL0 : ((sub_q == 2'd1) ? C_REPL1 : C_REPL2);
				pend  = (sub_q == 2'd2) && (rep_q == cur_q.repl_n - 3'd1);
			end
			PH_ASC: begin
				obyte = ebyte;
				pend  = idx_q == elen - 3'd1;
			end
			PH_CLOSE: begin
				obyte = C_QUOTE;
				send  = 1'b1;
			end
			default: begin
				obyte = C_QUOTE;
			end
		endcase
	end

	assign go      = !m_tvalid || m_tready;
	assign fire    = go && active_q;
	assign run_end = pend && (nxt == 5'd0);
	assign pop     = (!active_q || (fire && run_end)) && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
			active_q <= 1'b0;
			phase_q  <= PH_OPEN;
			idx_q    <= 3'd0;
			rep_q    <= 3'd0;
			sub_q    <= 2'd0;
		end else begin
			if (go) m_tvalid <= active_q;
			if (pop) begin
				active_q <= 1'b1;
				phase_q  <= ph_t'(head_ph);
				idx_q    <= 3'd0;
				rep_q    <= 3'd0;
				sub_q    <= 2'd0;
			end else if (fire) begin
				if (run_end) begin
					active_q <= 1'b0;
				end else if (pend) begin
					phase_q <= ph_t'(nxt);
					idx_q   <= 3'd0;
					rep_q   <= 3'd0;
					sub_q   <= 2'd0;
				end else if (phase_q == PH_REPL) begin
					if (sub_q == 2'd2) begin
						sub_q <= 2'd0;
						rep_q <= rep_q + 3'd1;
					end else begin
						sub_q <= sub_q + 2'd1;
					end
				end else begin
					idx_q <= idx_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) cur_q <= head;
		if (fire) begin
			m_tdata <= obyte;
			m_tlast <= run_end;
			m_tuser <= send;
		end
	end

endmodule
`default_nettype wire

// ----- design/json_string_escape_utf8_sanitize_unit.sv -----
// JSON string escaper with utf-8 sanitizing: top level
//
// Input stream s_*: one word per raw string byte. s_tdata is the byte,
// s_tlast marks the final item of a string (flush and closing quote),
// s_tuser[0] marks the first item (opening quote), s_tuser[1] marks an
// item that carries no byte. Output stream m_*: one word per byte of
// JSON text; m_tlast ends the words caused by one input item and m_tuser
// flags the closing quote.
// The front end takes one input word per cycle while its four-entry plan
// queue has room, so s_tready drops only when the queue is full. The back
// end emits one output byte per cycle unless m_tready stalls it; an item
// expands to 0 to 16 bytes, so with m_tready high the sustained input
// rate is one item per cycle for plain bytes and lower for items that
// expand to more bytes, set by the back end's single byte sequencer.
// From idle, an accepted word passes the queue, plan and output registers.
// Reset clears the utf-8 state, the queue and the output register; no
// string is open afterward. A stall on m_tready holds the output word and
// fills the queue, after which s_tready falls.
`timescale 1ns / 1ps
`default_nettype none
module json_string_escape_utf8_sanitize_unit (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire  [7:0] s_tdata,   // data_byte
	input  wire        s_tlast,   // last
	input  wire  [1:0] s_tuser,   // first, no_byte
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [7:0] m_tdata,   // out_byte
	output logic       m_tlast,   // run_last
	output logic       m_tuser    // string_end
);
	import jse_pkg::*;

	desc_t push_desc;
	desc_t head_desc;
	logic  push;
	logic  pop;
	logic  q_full;
	logic  q_empty;

	jse_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid     (s_tvalid),
		.ready     (s_tready),
		.data_byte (s_tdata),
		.first     (s_tuser[0]),
		.last      (s_tlast),
		.no_byte   (s_tuser[1]),
		.q_full    (q_full),
		.push      (push),
		.desc      (push_desc)
	);

	jse_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_desc),
		.pop    (pop),
		.dout   (head_desc),
		.full   (q_full),
		.empty  (q_empty)
	);

	jse_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head_desc),
		.q_empty  (q_empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule
`default_nettype wire

// ----- design/jse_checker.sv -----
// port-level checks for the json string escaper, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module jse_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       s_tvalid,
	input wire       s_tready,
	input wire [7:0] s_tdata,
	input wire       s_tlast,
	input wire [1:0] s_tuser,
	input wire       m_tvalid,
	input wire       m_tready,
	input wire [7:0] m_tdata,
	input wire       m_tlast,
	input wire       m_tuser
);

	// closing quote always ends its run
	a_close_quote: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast && m_tdata == 8'h22)
		else $error("closing quote not flagged as run end");

	// an EF byte (replacement lead or passed lead) is never the last word of a run
	a_lead: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata == 8'hEF |-> !m_tlast)
		else $error("lead byte ends a run");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
			$stable(m_tlast) && $stable(m_tuser))
		else $error("stalled output word changed");

endmodule

bind json_string_escape_utf8_sanitize_unit jse_checker u_jse_checker (.*);
`default_nettype wire
